// ----- src/bmp_pixel_row_unpacker_defines.svh -----
// assertion macros for the bmp pixel row unpacker
`ifndef BMP_PIXEL_ROW_UNPACKER_DEFINES_SVH
`define BMP_PIXEL_ROW_UNPACKER_DEFINES_SVH

`ifndef SYNTHESIS
`define BMPRU_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);
`define BMPRU_CHECK_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error(msg);
`else
`define BMPRU_CHECK(lbl, prop, msg)
`define BMPRU_CHECK_NEXT(lbl, pre, post, msg)
`endif

`endif

// ----- src/bmpru_pkg.sv -----
// shared constants and types for the bmp pixel row unpacker
package bmpru_pkg;

    localparam int OUT_DIM_W  = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;

    localparam logic [2:0] FMT_1BPP  = 3'd0;
    localparam logic [2:0] FMT_2BPP  = 3'd1;
    localparam logic [2:0] FMT_4BPP  = 3'd2;
    localparam logic [2:0] FMT_8BPP  = 3'd3;
    localparam logic [2:0] FMT_24BPP = 3'd4;
    localparam logic [2:0] FMT_48BPP = 3'd5;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PIXEL_FORMAT = 2'd0,
        REG_ROW_WIDTH    = 2'd1,
        REG_IMAGE_HEIGHT = 2'd2,
        REG_TOP_DOWN     = 2'd3
    } cfg_reg_t;

endpackage

// ----- src/bmp_pixel_row_unpacker.sv -----
// bmp pixel data decoder: bytes in, one pixel per result transaction out
// Takes pixel-data bytes in file order and emits one pixel per result
// transaction with its column and (mirrored) row. An 8, 24 or 48 bpp byte
// and every row padding byte is finished in one step; a 1, 2 or 4 bpp byte
// stays in the byte register until its pixels are out (8, 4 or 2, fewer at a
// row end), as the single result register takes one pixel per cycle if not
// stalled. A new byte is taken in the cycle its predecessor finishes, and
// while a finished pixel waits in the result register. There is no clearing
// pass after reset. Configuration must be written only while the block is
// idle (not enforced); a format write restarts the 24/48 bpp byte phase.
`include "bmp_pixel_row_unpacker_defines.svh"

module bmp_pixel_row_unpacker
    import bmpru_pkg::*;
#(
    parameter int DIM_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // input bytes
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] data_byte
    // result pixels
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [7:0] pixel_index, [15:8] red, [23:16] green, [31:24] blue,
    // [47:32] column, [63:48] row
    output logic [63:0]           m_tdata,
    output logic                  m_tuser,   // [0] last_in_row
    output logic                  m_tlast    // last_in_run
);

    // configuration
    logic [2:0]          fmt_reg;
    logic [DIM_BITS-1:0] width_reg, height_reg;
    logic                topdown_reg;

    // decode state
    logic [DIM_BITS-1:0] col_reg, col_next;
    logic [DIM_BITS-1:0] row_reg, row_next;
    logic [2:0]          phase_reg, phase_next;
    logic [1:0]          pad_reg, pad_next;
    logic [7:0]          hblue_reg, hblue_next;
    logic [7:0]          hgreen_reg, hgreen_next;

    // byte register
    logic                byte_vld_reg, byte_vld_next;
    logic [7:0]          sh_reg, sh_next;
    logic [2:0]          cnt_reg, cnt_next;

    // result register
    logic                m_vld_reg, m_vld_next;
    logic [7:0]          idx_o_reg, red_o_reg, green_o_reg, blue_o_reg;
    logic [DIM_BITS-1:0] col_o_reg, row_o_reg;
    logic                lrow_o_reg, lrun_o_reg;

    logic [DIM_BITS-1:0] eff_w, eff_h, row_mirror;
    logic [DIM_BITS:0]   col_plus, row_plus;
    logic                row_end, out_free, want_emit, byte_done, step;
    logic [7:0]          idx_val, red_val, green_val, blue_val;
    logic [1:0]          row_bytes_mod4;
    logic [4:0]          w_sum5;
    logic [3:0]          w_sum4;
    logic [2:0]          w_sum3;

    assign cfg_ready = 1'b1;

    assign eff_w = (width_reg == '0) ? DIM_BITS'(1) : width_reg;
    assign eff_h = (height_reg == '0) ? DIM_BITS'(1) : height_reg;

    assign col_plus   = {1'b0, col_reg} + (DIM_BITS+1)'(1);
    assign row_plus   = {1'b0, row_reg} + (DIM_BITS+1)'(1);
    assign row_end    = col_plus >= {1'b0, eff_w};
    assign row_mirror = topdown_reg ? row_reg : (eff_h - DIM_BITS'(1) - row_reg);

    // bytes per row, modulo 4, for the padding count
    assign w_sum5 = eff_w[4:0] + 5'd7;
    assign w_sum4 = eff_w[3:0] + 4'd3;
    assign w_sum3 = eff_w[2:0] + 3'd1;
    always_comb begin
        case (fmt_reg)
            FMT_1BPP:  row_bytes_mod4 = w_sum5[4:3];
            FMT_2BPP:  row_bytes_mod4 = w_sum4[3:2];
            FMT_4BPP:  row_bytes_mod4 = w_sum3[2:1];
            FMT_24BPP: row_bytes_mod4 = 2'd0 - eff_w[1:0];
            FMT_48BPP: row_bytes_mod4 = {eff_w[0], 1'b0};
            default:   row_bytes_mod4 = eff_w[1:0];
        endcase
    end

    // pixel value from the head of the byte register
    always_comb begin
        idx_val   = 8'd0;
        red_val   = 8'd0;
        green_val = 8'd0;
        blue_val  = 8'd0;
        case (fmt_reg) inside
            FMT_1BPP:  idx_val = {7'd0, sh_reg[7]};
            FMT_2BPP:  idx_val = {6'd0, sh_reg[7:6]};
            FMT_4BPP:  idx_val = {4'd0, sh_reg[7:4]};
            FMT_24BPP, FMT_48BPP: begin
                red_val   = sh_reg;
                green_val = hgreen_reg;
                blue_val  = hblue_reg;
            end
            default:   idx_val = sh_reg;
        endcase
    end

    // does the byte in the register produce a pixel now, and is it finished
    always_comb begin
        want_emit = 1'b0;
        byte_done = 1'b1;
        if (pad_reg == 2'd0) begin
            case (fmt_reg)
                FMT_24BPP: want_emit = (phase_reg >= 3'd2);
                FMT_48BPP: want_emit = (phase_reg == 3'd5);
                default: begin
                    want_emit = 1'b1;
                    byte_done = row_end || (cnt_reg == 3'd0);
                end
            endcase
        end
    end

    assign out_free = !m_vld_reg || m_tready;
    assign step     = byte_vld_reg && (!want_emit || out_free);
    assign s_tready = !byte_vld_reg || (step && byte_done);

    always_comb begin
        col_next      = col_reg;
        row_next      = row_reg;
        phase_next    = phase_reg;
        pad_next      = pad_reg;
        hblue_next    = hblue_reg;
        hgreen_next   = hgreen_reg;
        byte_vld_next = byte_vld_reg;
        sh_next       = sh_reg;
        cnt_next      = cnt_reg;

        if (step) begin
            if (pad_reg != 2'd0) begin
                pad_next = pad_reg - 2'd1;
            end else begin
                case (fmt_reg)
                    FMT_24BPP: begin
                        case (phase_reg)
                            3'd0:    begin hblue_next = sh_reg;  phase_next = 3'd1; end
                            3'd1:    begin hgreen_next = sh_reg; phase_next = 3'd2; end
                            default: phase_next = 3'd0;
                        endcase
                    end
                    FMT_48BPP: begin
                        case (phase_reg)
                            3'd1:    begin hblue_next = sh_reg;  phase_next = 3'd2; end
                            3'd3:    begin hgreen_next = sh_reg; phase_next = 3'd4; end
                            3'd5:    phase_next = 3'd0;
                            3'd6:    phase_next = 3'd1;
                            3'd7:    phase_next = 3'd2;
                            default: phase_next = phase_reg + 3'd1;
                        endcase
                    end
                    default: begin
                        cnt_next = cnt_reg - 3'd1;
                        case (fmt_reg)
                            FMT_1BPP: sh_next = {sh_reg[6:0], 1'b0};
                            FMT_2BPP: sh_next = {sh_reg[5:0], 2'b0};
                            FMT_4BPP: sh_next = {sh_reg[3:0], 4'b0};
                            default:  sh_next = sh_reg;
                        endcase
                    end
                endcase
                if (want_emit) begin
                    if (row_end) begin
                        col_next = '0;
                        pad_next = 2'd0 - row_bytes_mod4;
                        row_next = (row_plus >= {1'b0, eff_h}) ? '0 : row_plus[DIM_BITS-1:0];
                    end else begin
                        col_next = col_plus[DIM_BITS-1:0];
                    end
                end
            end
            if (byte_done) begin
                byte_vld_next = 1'b0;
            end
        end

        if (s_tvalid && s_tready) begin
            byte_vld_next = 1'b1;
            sh_next       = s_tdata;
            case (fmt_reg)
                FMT_1BPP: cnt_next = 3'd7;
                FMT_2BPP: cnt_next = 3'd3;
                FMT_4BPP: cnt_next = 3'd1;
                default:  cnt_next = 3'd0;
            endcase
        end

        // format change restarts the multi-byte pixel phase
        if (cfg_valid && cfg_ready && (cfg_reg_t'(cfg_index) == REG_PIXEL_FORMAT)) begin
            phase_next = 3'd0;
        end
    end

    always_comb begin
        if (step && want_emit) begin
            m_vld_next = 1'b1;
        end else if (m_tready) begin
            m_vld_next = 1'b0;
        end else begin
            m_vld_next = m_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fmt_reg      <= FMT_8BPP;
            width_reg    <= DIM_BITS'(1);
            height_reg   <= DIM_BITS'(1);
            topdown_reg  <= 1'b0;
            col_reg      <= '0;
            row_reg      <= '0;
            phase_reg    <= 3'd0;
            pad_reg      <= 2'd0;
            hblue_reg    <= 8'd0;
            hgreen_reg   <= 8'd0;
            byte_vld_reg <= 1'b0;
            cnt_reg      <= 3'd0;
            m_vld_reg    <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_PIXEL_FORMAT: fmt_reg     <= cfg_data[2:0];
                    REG_ROW_WIDTH:    width_reg   <= cfg_data[DIM_BITS-1:0];
                    REG_IMAGE_HEIGHT: height_reg  <= cfg_data[DIM_BITS-1:0];
                    REG_TOP_DOWN:     topdown_reg <= cfg_data[0];
                endcase
            end
            col_reg      <= col_next;
            row_reg      <= row_next;
            phase_reg    <= phase_next;
            pad_reg      <= pad_next;
            hblue_reg    <= hblue_next;
            hgreen_reg   <= hgreen_next;
            byte_vld_reg <= byte_vld_next;
            cnt_reg      <= cnt_next;
            m_vld_reg    <= m_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        sh_reg <= sh_next;
        if (step && want_emit) begin
            idx_o_reg   <= idx_val;
            red_o_reg   <= red_val;
            green_o_reg <= green_val;
            blue_o_reg  <= blue_val;
            col_o_reg   <= col_reg;
            row_o_reg   <= row_mirror;
            lrow_o_reg  <= row_end;
            lrun_o_reg  <= byte_done;
        end
    end

    assign m_tvalid = m_vld_reg;
    assign m_tdata  = {OUT_DIM_W'(row_o_reg), OUT_DIM_W'(col_o_reg),
                       blue_o_reg, green_o_reg, red_o_reg, idx_o_reg};
    assign m_tuser  = lrow_o_reg;
    assign m_tlast  = lrun_o_reg;

    // padding only starts at a row end, so the column is back at zero
    `BMPRU_CHECK(a_pad_at_col0, (pad_reg == 2'd0) || (col_reg == '0), "padding with column set")
    `BMPRU_CHECK(a_phase_range, phase_reg <= 3'd5, "byte phase out of range")
    `BMPRU_CHECK_NEXT(a_stall_keeps_byte, byte_vld_reg && want_emit && m_vld_reg && !m_tready,
        byte_vld_reg && $stable(sh_reg), "stalled byte lost")

endmodule
